>>> hw/rtl/btr_pkg.sv
// ----------------------------------------------------------------------------
// btr_pkg - shared definitions for the bitmap text rasterizer
// Field widths, default sizes, register indexes, item kinds and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package btr_pkg;

    // Default font store geometry
    localparam int CODE_COUNT     = 256;
    localparam int MAX_GLYPH_ROWS = 16;

    // Field widths
    localparam int ROW_W    = 16;
    localparam int COORD_W  = 13;
    localparam int COLOR_W  = 24;
    localparam int STATUS_W = 2;
    localparam int CODE_W   = 8;
    localparam int RIDX_W   = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Most rows emitted for one character
    localparam int MAX_EMIT = 16;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_X      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_Y      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_COLOR   = 3'd6;

    // Input item kinds
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_DRAW = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_SPACE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_DROPPED  = 2'd2;

endpackage

`default_nettype wire

>>> hw/rtl/btr_font_mem.sv
// ----------------------------------------------------------------------------
// btr_font_mem - glyph row store
// Simple dual-port synchronous RAM: one write port, one read port, read data
// registered and held until the next read.
// ----------------------------------------------------------------------------
`default_nettype none

module btr_font_mem #(
    parameter int DEPTH  = btr_pkg::CODE_COUNT * btr_pkg::MAX_GLYPH_ROWS,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [ADDR_W-1:0]        i_waddr,
    input  wire logic [btr_pkg::ROW_W-1:0] i_wdata,
    input  wire logic                     i_re,
    input  wire logic [ADDR_W-1:0]        i_raddr,
    output logic      [btr_pkg::ROW_W-1:0] o_rdata
);

    logic [btr_pkg::ROW_W-1:0] r_mem [DEPTH];

    // Write one row
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read one row, hold between reads
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/bitmap_text_rasterizer_core.sv
// ----------------------------------------------------------------------------
// bitmap_text_rasterizer_core - bitmap font character generator
// Loads glyph rows into a font store and turns each drawn character into one
// result per glyph row, with cursor advance, line wrap and out-of-space halt.
//
//   channel   dir  handshake                  content
//   s_axis    in   tvalid/tready              tuser: kind, tdata: load or draw
//   m_axis    out  tvalid/tready/tlast        tuser: status, tdata: one row
//   cfg       in   we (no wait)               index, data
//
// A draw item is accepted, then one row read is issued per cycle while the
// output does not stall (min(glyph_height,16) rows, at least one), set by the
// single read port of the font store; each row passes the read stage and the
// output register. After reset a clearing pass zeroes the store, one entry a
// cycle over all CODE_COUNT*MAX_GLYPH_ROWS entries (4096 by default), while no
// item is accepted. A stalled output holds the read stage and the row issue.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_text_rasterizer_core #(
    parameter int CODE_COUNT     = btr_pkg::CODE_COUNT,
    parameter int MAX_GLYPH_ROWS = btr_pkg::MAX_GLYPH_ROWS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input items
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // tdata: char_code[7:0], row_index[11:8], row_bits[27:12], new_text[28]
    input  wire logic [31:0] i_s_axis_tdata,
    // tuser: kind
    input  wire logic        i_s_axis_tuser,
    // Result items
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // tdata: pixel_x[12:0], pixel_y[25:13], row_mask[41:26], color[65:42]
    output logic      [71:0] o_m_axis_tdata,
    // tuser: status
    output logic      [1:0]  o_m_axis_tuser,
    output logic             o_m_axis_tlast,
    // Configuration writes
    input  wire logic                             i_cfg_we,
    input  wire logic [btr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [btr_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int DEPTH  = CODE_COUNT * MAX_GLYPH_ROWS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CW     = btr_pkg::COORD_W;
    localparam int RW     = btr_pkg::ROW_W;
    localparam int IW     = btr_pkg::RIDX_W;

    typedef enum logic {
        ST_IDLE,
        ST_DRAW
    } t_state;

    // Input fields
    logic [btr_pkg::CODE_W-1:0] s_code;
    logic [IW-1:0]              s_row_idx;
    logic [RW-1:0]              s_row_bits;
    logic                       s_new_text;
    assign s_code     = i_s_axis_tdata[7:0];
    assign s_row_idx  = i_s_axis_tdata[11:8];
    assign s_row_bits = i_s_axis_tdata[27:12];
    assign s_new_text = i_s_axis_tdata[28];

    // Configuration registers
    logic [11:0] r_start_x, r_start_y;
    logic [4:0]  r_glyph_w, r_glyph_h;
    logic [12:0] r_image_w, r_image_h;
    logic [btr_pkg::COLOR_W-1:0] r_color;

    // Control state
    t_state       r_state;
    logic [CW-1:0] r_cur_x, r_cur_y;
    logic          r_halted;
    logic          r_clr_active;
    logic [ADDR_W-1:0] r_clr_addr;

    // Current draw job
    logic [btr_pkg::CODE_W-1:0] r_job_code;
    logic [CW-1:0]  r_job_x, r_job_y;
    logic [1:0]     r_job_status;
    logic           r_job_blank;
    logic [IW-1:0]  r_job_last;
    logic [IW-1:0]  r_row;

    // Read stage
    logic           r_rd_v;
    logic [CW-1:0]  r_rd_x, r_rd_y;
    logic [1:0]     r_rd_status;
    logic           r_rd_last, r_rd_blank;

    // Output register
    logic           r_out_v;
    logic [CW-1:0]  r_out_x, r_out_y;
    logic [RW-1:0]  r_out_mask;
    logic [btr_pkg::COLOR_W-1:0] r_out_color;
    logic [1:0]     r_out_status;
    logic           r_out_last;

    // Combinational values
    logic          acc, acc_load, acc_draw;
    logic          load_code_ok, load_row_ok, draw_code_ok, row_ok;
    logic [CW-1:0] eff_x, eff_y;
    logic          eff_halt;
    logic [CW:0]   sum_x, sum_y;
    logic          fits_x, fits_y;
    logic [CW-1:0] n_cur_x, n_cur_y;
    logic          n_halted;
    logic [1:0]    n_job_status;
    logic          n_job_blank;
    logic [IW-1:0] n_job_last;
    logic          out_load, issue;
    logic [ADDR_W-1:0] load_addr, read_addr;
    logic [RW-1:0] load_data;
    logic          mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [RW-1:0] mem_wdata, mem_rdata;

    assign o_s_axis_tready = !r_clr_active && (r_state == ST_IDLE);
    assign acc      = i_s_axis_tvalid && o_s_axis_tready;
    assign acc_load = acc && (i_s_axis_tuser == btr_pkg::KIND_LOAD);
    assign acc_draw = acc && (i_s_axis_tuser == btr_pkg::KIND_DRAW);

    assign load_code_ok = {9'd0, s_code} < 17'(CODE_COUNT);
    assign load_row_ok  = {2'd0, s_row_idx} < 6'(MAX_GLYPH_ROWS);
    assign draw_code_ok = {9'd0, r_job_code} < 17'(CODE_COUNT);
    assign row_ok       = {2'd0, r_row} < 6'(MAX_GLYPH_ROWS);

    // Font store addresses: code * rows + row
    assign load_addr = ADDR_W'(32'(s_code) * 32'(MAX_GLYPH_ROWS) + 32'(s_row_idx));
    assign read_addr = ADDR_W'(32'(r_job_code) * 32'(MAX_GLYPH_ROWS) + 32'(r_row));

    // Left-align narrow glyphs
    assign load_data = (r_glyph_w <= 5'd8) ? {s_row_bits[7:0], 8'd0} : s_row_bits;

    // Write port: clearing pass, else loads
    always_comb begin
        if (r_clr_active) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = '0;
        end else begin
            mem_we    = acc_load && load_code_ok && load_row_ok;
            mem_waddr = load_addr;
            mem_wdata = load_data;
        end
    end

    // Cursor decision for a draw item
    always_comb begin
        eff_x    = s_new_text ? {1'b0, r_start_x} : r_cur_x;
        eff_y    = s_new_text ? {1'b0, r_start_y} : r_cur_y;
        eff_halt = s_new_text ? 1'b0 : r_halted;
        sum_x    = {1'b0, eff_x} + {8'd0, r_glyph_w, 1'b0};
        sum_y    = {1'b0, eff_y} + {8'd0, r_glyph_h, 1'b0};
        fits_x   = sum_x <= {1'b0, r_image_w};
        fits_y   = sum_y < {1'b0, r_image_h};
        n_cur_x  = eff_x;
        n_cur_y  = eff_y;
        n_halted = eff_halt;
        n_job_status = btr_pkg::STATUS_OK;
        if (eff_halt) begin
            n_job_status = btr_pkg::STATUS_DROPPED;
        end else if (fits_x) begin
            n_cur_x = eff_x + {8'd0, r_glyph_w};
        end else if (fits_y) begin
            n_cur_x = {1'b0, r_start_x};
            n_cur_y = eff_y + {8'd0, r_glyph_h};
        end else begin
            n_halted     = 1'b1;
            n_job_status = btr_pkg::STATUS_NO_SPACE;
        end
        // Row count: dropped and zero-height draws give one blank row
        n_job_blank = eff_halt || (r_glyph_h == 5'd0) ||
                      !({9'd0, s_code} < 17'(CODE_COUNT));
        if (eff_halt || (r_glyph_h == 5'd0)) begin
            n_job_last = '0;
        end else if (r_glyph_h >= 5'(btr_pkg::MAX_EMIT)) begin
            n_job_last = IW'(btr_pkg::MAX_EMIT - 1);
        end else begin
            n_job_last = IW'(r_glyph_h - 5'd1);
        end
    end

    // Row issue and stage advance
    assign out_load = r_rd_v && (!r_out_v || i_m_axis_tready);
    assign issue    = (r_state == ST_DRAW) && (!r_rd_v || out_load);

    btr_font_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_font_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (issue),
        .i_raddr (read_addr),
        .o_rdata (mem_rdata)
    );

    // State, cursor, stages and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_cur_x      <= '0;
            r_cur_y      <= '0;
            r_halted     <= 1'b0;
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
            r_start_x    <= 12'd0;
            r_start_y    <= 12'd0;
            r_glyph_w    <= 5'd8;
            r_glyph_h    <= 5'd16;
            r_image_w    <= 13'd640;
            r_image_h    <= 13'd480;
            r_color      <= 24'hFFFFFF;
            r_rd_v       <= 1'b0;
            r_out_v      <= 1'b0;
        end else begin
            // Sweep the store after reset
            if (r_clr_active) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
                if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                    r_clr_active <= 1'b0;
                end
            end

            // Register writes
            if (i_cfg_we) begin
                case (i_cfg_index)
                    btr_pkg::CFG_START_X:      r_start_x <= i_cfg_data[11:0];
                    btr_pkg::CFG_START_Y:      r_start_y <= i_cfg_data[11:0];
                    btr_pkg::CFG_GLYPH_WIDTH:  r_glyph_w <= i_cfg_data[4:0];
                    btr_pkg::CFG_GLYPH_HEIGHT: r_glyph_h <= i_cfg_data[4:0];
                    btr_pkg::CFG_IMAGE_WIDTH:  r_image_w <= i_cfg_data[12:0];
                    btr_pkg::CFG_IMAGE_HEIGHT: r_image_h <= i_cfg_data[12:0];
                    btr_pkg::CFG_TEXT_COLOR:   r_color   <= i_cfg_data;
                    default: ;
                endcase
            end

            // Job control
            case (r_state)
                ST_IDLE: begin
                    if (acc_draw) begin
                        r_job_code   <= s_code;
                        r_job_x      <= eff_x;
                        r_job_y      <= eff_y;
                        r_job_status <= n_job_status;
                        r_job_blank  <= n_job_blank;
                        r_job_last   <= n_job_last;
                        r_row        <= '0;
                        r_cur_x      <= n_cur_x;
                        r_cur_y      <= n_cur_y;
                        r_halted     <= n_halted;
                        r_state      <= ST_DRAW;
                    end
                end
                ST_DRAW: begin
                    if (issue) begin
                        r_row <= r_row + IW'(1);
                        if (r_row == r_job_last) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase

            // Read stage: capture row info alongside the memory read
            if (issue) begin
                r_rd_v      <= 1'b1;
                r_rd_x      <= r_job_x;
                r_rd_y      <= r_job_y + {9'd0, r_row};
                r_rd_status <= r_job_status;
                r_rd_last   <= (r_row == r_job_last);
                r_rd_blank  <= r_job_blank || !draw_code_ok || !row_ok;
            end else if (out_load) begin
                r_rd_v <= 1'b0;
            end

            // Output register
            if (out_load) begin
                r_out_v      <= 1'b1;
                r_out_x      <= r_rd_x;
                r_out_y      <= r_rd_y;
                r_out_mask   <= r_rd_blank ? '0 : mem_rdata;
                r_out_color  <= r_color;
                r_out_status <= r_rd_status;
                r_out_last   <= r_rd_last;
            end else if (i_m_axis_tready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = {6'd0, r_out_color, r_out_mask, r_out_y, r_out_x};
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tlast  = r_out_last;

`ifndef SYNTHESIS
    // A row waiting in the read stage is kept until the output takes it
    a_rd_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_v && !out_load |=> r_rd_v)
        else $error("read stage row lost while output stalled");

    // A dropped character is a single, final result
    a_drop_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser == btr_pkg::STATUS_DROPPED) |-> o_m_axis_tlast)
        else $error("dropped status on a non-final result");

    // Row reads never meet a store write in the same cycle
    a_no_rw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        issue |-> !mem_we)
        else $error("font store read and write collide");

    // No drawing while the clearing pass runs
    a_clr_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_active |-> (r_state == ST_IDLE) && !r_rd_v && !r_out_v)
        else $error("draw activity during clearing pass");
`endif

endmodule

`default_nettype wire

>>> bench/btr_row_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btr_row_checker - row predictor and scoreboard for the text rasterizer
// Watches the input, configuration and result channels of the core. Keeps its
// own font store, cursor, halt flag and register copies, and queues the glyph
// rows each drawn character must produce. Each result taken from the core is
// compared field by field against the oldest queued row.
// ----------------------------------------------------------------------------
module btr_row_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Input channel
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    // char_code[7:0], row_index[11:8], row_bits[27:12], new_text[28]
    input  logic [31:0]                    i_s_tdata,
    // kind
    input  logic                           i_s_tuser,
    // Result channel
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    // pixel_x[12:0], pixel_y[25:13], row_mask[41:26], color[65:42]
    input  logic [71:0]                    i_m_tdata,
    // status
    input  logic [1:0]                     i_m_tuser,
    input  logic                           i_m_tlast,
    // Configuration writes
    input  logic                           i_cfg_we,
    input  logic [btr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [btr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // Scoreboard state for the bench top
    output int                             o_mismatches,
    output int                             o_rows_due
);
    import btr_pkg::*;

    localparam int STORE_DEPTH  = CODE_COUNT * MAX_GLYPH_ROWS;

    typedef struct packed {
        logic [COORD_W-1:0]  pixel_x;
        logic [COORD_W-1:0]  pixel_y;
        logic [ROW_W-1:0]    row_mask;
        logic [COLOR_W-1:0]  color;
        logic [STATUS_W-1:0] status;
        logic                last;
    } t_glyph_row;

    t_glyph_row       rows_due [$];
    logic [ROW_W-1:0] font_rows [STORE_DEPTH];

    // Cursor and register copies
    int unsigned      cur_x, cur_y;
    logic             halt_flag;
    int unsigned      start_x, start_y, glyph_w, glyph_h, image_w, image_h;
    logic [COLOR_W-1:0] ink;

    // Queue one expected row with the current text color
    task automatic push_row(input int unsigned px, input int unsigned py,
                            input logic [ROW_W-1:0] mask,
                            input logic [STATUS_W-1:0] st, input logic fin);
        t_glyph_row r;
        r.pixel_x  = px[COORD_W-1:0];
        r.pixel_y  = py[COORD_W-1:0];
        r.row_mask = mask;
        r.color    = ink;
        r.status   = st;
        r.last     = fin;
        rows_due.insert(rows_due.size(), r);
    endtask

    task automatic check_field(input string fname, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, got %0h",
                     $time, fname, want, got);
            o_mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : scoreboard
        t_glyph_row       want;
        logic [CODE_W-1:0] code;
        logic [RIDX_W-1:0] ridx;
        logic [ROW_W-1:0]  bits;
        logic              fresh;
        int unsigned       nx, ny, rows;
        logic [STATUS_W-1:0] st;

        if (!i_rst_n) begin
            // Back to power-on state: empty store, home cursor, default layout
            for (int k = 0; k < STORE_DEPTH; k++)
                font_rows[k] = '0;
            rows_due.delete();
            cur_x     = 0;
            cur_y     = 0;
            halt_flag = 1'b0;
            start_x   = 0;
            start_y   = 0;
            glyph_w   = 8;
            glyph_h   = 16;
            image_w   = 640;
            image_h   = 480;
            ink       = 24'hFFFFFF;
        end else begin
            // Compare a taken result against the oldest expected row
            if (i_m_tvalid && i_m_tready) begin
                if (rows_due.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got %h/%h/%b",
                             $time, i_m_tdata, i_m_tuser, i_m_tlast);
                    o_mismatches++;
                end else begin
                    want = rows_due.pop_front();
                    check_field("pixel_x",  want.pixel_x,  i_m_tdata[12:0]);
                    check_field("pixel_y",  want.pixel_y,  i_m_tdata[25:13]);
                    check_field("row_mask", want.row_mask, i_m_tdata[41:26]);
                    check_field("color",    want.color,    i_m_tdata[65:42]);
                    check_field("status",   want.status,   i_m_tuser);
                    check_field("last",     want.last,     i_m_tlast);
                end
            end

            // Track register writes
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_START_X:      start_x = 32'(i_cfg_data[11:0]);
                    CFG_START_Y:      start_y = 32'(i_cfg_data[11:0]);
                    CFG_GLYPH_WIDTH:  glyph_w = 32'(i_cfg_data[4:0]);
                    CFG_GLYPH_HEIGHT: glyph_h = 32'(i_cfg_data[4:0]);
                    CFG_IMAGE_WIDTH:  image_w = 32'(i_cfg_data[12:0]);
                    CFG_IMAGE_HEIGHT: image_h = 32'(i_cfg_data[12:0]);
                    CFG_TEXT_COLOR:   ink     = i_cfg_data[23:0];
                    default: ;
                endcase
            end

            // Predict the rows of an accepted item
            if (i_s_tvalid && i_s_tready) begin
                code  = i_s_tdata[7:0];
                ridx  = i_s_tdata[11:8];
                bits  = i_s_tdata[27:12];
                fresh = i_s_tdata[28];
                if (i_s_tuser == KIND_LOAD) begin
                    // Narrow glyphs are stored left-aligned
                    if (glyph_w <= 8)
                        bits = {bits[7:0], 8'h00};
                    font_rows[code * MAX_GLYPH_ROWS + ridx] = bits;
                end else begin
                    if (fresh) begin
                        cur_x     = start_x;
                        cur_y     = start_y;
                        halt_flag = 1'b0;
                    end
                    if (halt_flag) begin
                        // Dropped while halted: one empty row, cursor holds
                        push_row(cur_x, cur_y, '0, STATUS_DROPPED, 1'b1);
                    end else begin
                        // Decide advance, wrap or halt before emitting rows
                        nx = cur_x;
                        ny = cur_y;
                        st = STATUS_OK;
                        if (cur_x + 2 * glyph_w <= image_w) begin
                            nx = cur_x + glyph_w;
                        end else if (cur_y + 2 * glyph_h < image_h) begin
                            nx = start_x;
                            ny = cur_y + glyph_h;
                        end else begin
                            halt_flag = 1'b1;
                            st        = STATUS_NO_SPACE;
                        end
                        rows = (glyph_h < MAX_EMIT) ? glyph_h : MAX_EMIT;
                        if (rows == 0) begin
                            push_row(cur_x, cur_y, '0, st, 1'b1);
                        end else begin
                            for (int r = 0; r < rows; r++)
                                push_row(cur_x, cur_y + r,
                                         font_rows[code * MAX_GLYPH_ROWS + r], st,
                                         r + 1 == rows);
                        end
                        cur_x = nx & 32'h1FFF;
                        cur_y = ny & 32'h1FFF;
                    end
                end
            end
        end
        o_rows_due = rows_due.size();
    end

endmodule

>>> bench/tb_bitmap_text_rasterizer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bitmap_text_rasterizer_core - stimulus and verdict for the text rasterizer
// Loads glyph rows and draws text strings under a series of layouts, from the
// reset defaults through extreme register values, with random idling on both
// channels and one long result back-pressure stretch. Checking is done by the
// row checker instantiated beside the core.
// ----------------------------------------------------------------------------
module tb_bitmap_text_rasterizer_core;
    import btr_pkg::*;

    localparam int CLK_HALF      = 2;
    localparam int RESET_CYCLES  = 11;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = 10;
    localparam int DRAIN_CYCLES  = 40;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_ITEMS  = 190;
    localparam int PHASE_ITEMS   = 26;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [31:0]           s_tdata   = '0;
    logic                  s_tuser   = KIND_LOAD;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [71:0]           m_tdata;
    logic [1:0]            m_tuser;
    logic                  m_tlast;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_START_X;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int mismatch_count;
    int rows_outstanding;
    int cycle_count   = 0;
    int tx_idle_pct   = 0;
    int rx_idle_pct   = 0;
    int hold_requests = 0;

    bitmap_text_rasterizer_core DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    btr_row_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_m_tlast    (m_tlast),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_mismatches (mismatch_count),
        .o_rows_due   (rows_outstanding)
    );

    always begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Mostly short idle stretches, now and then a long one
    function automatic int idle_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    // Result sink: random idling, plus a long hold-off when requested
    initial begin : result_sink
        int len;
        int holds_done;
        holds_done = 0;
        forever begin
            @(negedge clk);
            if (holds_done != hold_requests) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                holds_done++;
            end else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
                len = idle_len();
                m_tready <= 1'b0;
                repeat (len - 1) @(negedge clk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Offer one item and hold it until taken, then maybe idle
    task automatic send_item(input logic kind, input logic [CODE_W-1:0] code,
                             input logic [RIDX_W-1:0] ridx,
                             input logic [ROW_W-1:0] bits, input logic fresh);
        int gap;
        @(negedge clk);
        s_tuser  <= kind;
        s_tdata  <= {3'b000, fresh, bits, ridx, code};
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            gap = idle_len();
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic load_row(input logic [CODE_W-1:0] code, input logic [RIDX_W-1:0] ridx,
                            input logic [ROW_W-1:0] bits);
        send_item(KIND_LOAD, code, ridx, bits, 1'($urandom));
    endtask

    task automatic draw_char(input logic [CODE_W-1:0] code, input logic fresh);
        send_item(KIND_DRAW, code, 4'($urandom), 16'($urandom), fresh);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Stop offering, wait for every row, then let the last load settle
    task automatic drain_rows();
        @(negedge clk);
        s_tvalid <= 1'b0;
        wait (rows_outstanding == 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial begin : stimulus
        logic [CODE_W-1:0] hot [4];
        logic [CODE_W-1:0] code;
        int items_left, phase_items, pick, len, mode;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // Reset layout: narrow glyph rows are left-aligned on load
        load_row(8'h00, 4'h0, 16'hFFFF);
        load_row(8'hFF, 4'hF, 16'h8001);
        load_row(8'hFF, 4'h0, 16'h00FF);
        draw_char(8'h00, 1'b1);
        draw_char(8'hFF, 1'b0);
        draw_char(8'h41, 1'b0);
        drain_rows();

        // Tiny image: advance, wrap, run out of space, drop, restart
        write_reg(CFG_START_X, 24'd0);
        write_reg(CFG_START_Y, 24'd0);
        write_reg(CFG_GLYPH_WIDTH, 24'd16);
        write_reg(CFG_GLYPH_HEIGHT, 24'd16);
        write_reg(CFG_IMAGE_WIDTH, 24'd40);
        write_reg(CFG_IMAGE_HEIGHT, 24'd40);
        write_reg(CFG_TEXT_COLOR, 24'h123456);
        load_row(8'h80, 4'h0, 16'h8001);
        load_row(8'h80, 4'hF, 16'hFFFF);
        draw_char(8'h80, 1'b1);
        draw_char(8'h80, 1'b0);
        draw_char(8'h00, 1'b0);
        draw_char(8'hFF, 1'b0);
        draw_char(8'h80, 1'b0);
        draw_char(8'h80, 1'b1);
        drain_rows();

        // Zero sizes: zero-height glyph halts at once, then is dropped
        write_reg(CFG_START_X, 24'd4095);
        write_reg(CFG_START_Y, 24'd4095);
        write_reg(CFG_GLYPH_WIDTH, 24'd0);
        write_reg(CFG_GLYPH_HEIGHT, 24'd0);
        write_reg(CFG_IMAGE_WIDTH, 24'd0);
        write_reg(CFG_IMAGE_HEIGHT, 24'd0);
        write_reg(CFG_TEXT_COLOR, 24'h000000);
        load_row(8'h7E, 4'h5, 16'hA5C3);
        draw_char(8'h80, 1'b1);
        draw_char(8'h80, 1'b0);
        drain_rows();

        // Largest sizes: tall glyph emits sixteen rows, wide rows unshifted
        write_reg(CFG_GLYPH_WIDTH, 24'd31);
        write_reg(CFG_GLYPH_HEIGHT, 24'd31);
        write_reg(CFG_IMAGE_WIDTH, 24'd8191);
        write_reg(CFG_IMAGE_HEIGHT, 24'd8191);
        write_reg(CFG_TEXT_COLOR, 24'hFFFFFF);
        load_row(8'h7E, 4'hA, 16'h5A3C);
        draw_char(8'h7E, 1'b1);
        draw_char(8'h00, 1'b0);
        drain_rows();

        // Random phases: new layout, glyph loads and text strings
        items_left = RANDOM_ITEMS;
        for (int p = 0; items_left > 0; p++) begin
            mode = $urandom_range(0, 7);
            write_reg(CFG_START_X, (mode == 0) ? 24'd4095 : 24'($urandom_range(0, 48)));
            write_reg(CFG_START_Y, (mode == 0) ? 24'd4095 : 24'($urandom_range(0, 48)));
            if (mode == 1)
                write_reg(CFG_GLYPH_WIDTH, $urandom_range(0, 1) ? 24'd31 : 24'd0);
            else
                write_reg(CFG_GLYPH_WIDTH, 24'($urandom_range(1, 16)));
            if (mode == 2)
                write_reg(CFG_GLYPH_HEIGHT,
                          $urandom_range(0, 1) ? 24'($urandom_range(17, 31)) : 24'd0);
            else
                write_reg(CFG_GLYPH_HEIGHT, 24'($urandom_range(1, 16)));
            if (mode == 0) begin
                write_reg(CFG_IMAGE_WIDTH, 24'd8191);
                write_reg(CFG_IMAGE_HEIGHT, 24'd8191);
            end else if (mode == 3) begin
                write_reg(CFG_IMAGE_WIDTH, 24'($urandom_range(0, 8191)));
                write_reg(CFG_IMAGE_HEIGHT, 24'($urandom_range(0, 8191)));
            end else begin
                write_reg(CFG_IMAGE_WIDTH, 24'($urandom_range(16, 160)));
                write_reg(CFG_IMAGE_HEIGHT, 24'($urandom_range(16, 120)));
            end
            write_reg(CFG_TEXT_COLOR, 24'($urandom));

            tx_idle_pct = (p % 3 == 0) ? 0 : $urandom_range(10, 50);
            rx_idle_pct = (p % 3 == 1) ? 0 : $urandom_range(10, 50);
            for (int h = 0; h < 4; h++)
                hot[h] = 8'($urandom_range(0, 255));
            // Long result hold-off while the sender keeps offering
            if (p == 0)
                hold_requests++;

            phase_items = 0;
            while (phase_items < PHASE_ITEMS && items_left > 0) begin
                pick = $urandom_range(0, 9);
                if (pick < 3) begin
                    len = $urandom_range(1, 6);
                    repeat (len)
                        load_row(hot[$urandom_range(0, 3)], 4'($urandom), 16'($urandom));
                end else if (pick < 9) begin
                    len = $urandom_range(2, 8);
                    for (int c = 0; c < len; c++) begin
                        code = ($urandom_range(0, 4) == 0) ? 8'($urandom)
                                                           : hot[$urandom_range(0, 3)];
                        draw_char(code, c == 0);
                    end
                end else begin
                    len = 1;
                    draw_char(8'($urandom), 1'($urandom));
                end
                phase_items += len;
                items_left  -= len;
            end
            drain_rows();
        end

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
